@@ rtl/cau_pkg.sv @@
package cau_pkg;

    localparam int DataW     = 32;
    localparam int FracBits  = 16;
    localparam int ActW      = 2;
    localparam int TdataInW  = 136;
    localparam int TdataOutW = 64;
    localparam int QW        = 41;

    localparam logic [ActW-1:0] ACT_ADD = 2'd0;
    localparam logic [ActW-1:0] ACT_SUB = 2'd1;
    localparam logic [ActW-1:0] ACT_MUL = 2'd2;
    localparam logic [ActW-1:0] ACT_DIV = 2'd3;

    // Per-item side information that travels alongside the pipeline data.
    typedef struct packed {
        logic [ActW-1:0]  action;
        logic [DataW-1:0] a_re;
        logic [DataW-1:0] a_im;
    } t_tag;

    // Saturate a sign/magnitude value to 32-bit two's complement.
    function automatic logic [DataW:0] sat_sm(input logic neg, input logic [63:0] mag,
                                              input logic big);
        logic [DataW:0] r;
        if (!neg) begin
            if (big || mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
            else                            r = {1'b0, mag[DataW-1:0]};
        end else begin
            if (big || mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
            else                            r = {1'b0, 32'(0 - mag[DataW-1:0])};
        end
        return r;
    endfunction

endpackage

@@ rtl/cau_mul.sv @@
// Registered signed 32x32 multiply returning sign and 64-bit magnitude.
module cau_mul
    import cau_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DataW-1:0] i_x,
    input  logic [DataW-1:0] i_y,
    output logic             o_neg,
    output logic [63:0]      o_mag
);
    logic [DataW-1:0] n_ax, n_ay;
    logic             r_neg;
    logic [63:0]      r_mag;

    always_comb begin
        n_ax = i_x[DataW-1] ? 32'(0 - i_x) : i_x;
        n_ay = i_y[DataW-1] ? 32'(0 - i_y) : i_y;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= 64'(n_ax) * 64'(n_ay);
            r_neg <= i_x[DataW-1] ^ i_y[DataW-1];
        end
    end

    assign o_neg = r_neg && (r_mag != 64'd0);
    assign o_mag = r_mag;
endmodule

@@ rtl/cau_divpipe.sv @@
// Pipelined restoring divider: one quotient bit per stage, QW stages.
// Quotient of (num << FRAC) / den; o_big flags a quotient of 2^(QW-1) or more.
module cau_divpipe
    import cau_pkg::*;
#(
    parameter int FRAC = FracBits
)(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic [QW-1:0] o_q,
    output logic        o_big
);
    // The quotient reaches 2^(QW-1) exactly when the dividend bits above the
    // low QW-1 positions, taken alone, are at least den. Otherwise they form
    // the starting remainder and the low bits are shifted in one per stage.
    localparam int NB = 64 + FRAC;
    localparam int PW = NB - (QW - 1);    // prefix bits

    logic [NB-1:0]   w_dvd;
    logic [PW-1:0]   w_pre;
    logic            w_pbig;

    logic [QW-2:0]   r_lo  [QW];
    logic [64:0]     r_rem [QW];
    logic [QW-2:0]   r_q   [QW];
    logic [63:0]     r_den [QW];
    logic            r_big [QW];

    assign w_dvd  = {i_num, {FRAC{1'b0}}};
    assign w_pre  = w_dvd[NB-1 -: PW];
    assign w_pbig = (65'(w_pre) >= 65'(i_den));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo[0]  <= w_dvd[QW-2:0];
            r_rem[0] <= w_pbig ? 65'd0 : 65'(w_pre);
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_big[0] <= w_pbig;
            for (int s = 1; s < QW; s++) begin
                logic [65:0] t;
                t = {r_rem[s-1], r_lo[s-1][QW-2]};
                r_lo[s]  <= {r_lo[s-1][QW-3:0], 1'b0};
                r_den[s] <= r_den[s-1];
                r_big[s] <= r_big[s-1];
                if (t >= 66'(r_den[s-1])) begin
                    r_rem[s] <= 65'(t - 66'(r_den[s-1]));
                    r_q[s]   <= {r_q[s-1][QW-3:0], 1'b1};
                end else begin
                    r_rem[s] <= 65'(t);
                    r_q[s]   <= {r_q[s-1][QW-3:0], 1'b0};
                end
            end
        end
    end

    assign o_big = r_big[QW-1];
    assign o_q   = {1'b0, r_q[QW-1]};
endmodule

@@ rtl/complex_arithmetic_unit.sv @@
// Channel   Dir  Signals                           Content
// s_axis    in   s_axis_tvalid/tready/tdata[135:0] action, a_re, a_im, b_re, b_im
// m_axis    out  m_axis_tvalid/tready/tdata[63:0]  res_re, res_im
//                m_axis_tuser[1:0]                 zero_divisor, overflow
// Every operation takes the same path; one transaction is accepted per
// cycle while the output is not stalled. The depth comes from the divider,
// one quotient bit per stage. Reset clears only the valid bits. A stall
// on the output freezes the whole pipeline, so nothing is lost or repeated.
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = FracBits
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TdataInW-1:0]  s_axis_tdata,   // action, a_re, a_im, b_re, b_im
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TdataOutW-1:0] m_axis_tdata,   // res_re, res_im
    output logic [1:0]           m_axis_tuser    // zero_divisor, overflow
);
    localparam int LAT = QW + 3;

    logic w_en;
    logic [LAT-1:0] r_vld;

    // Advance everything together whenever the output slot can move.
    assign w_en          = m_axis_tready || !r_vld[LAT-1];
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    t_tag             w_tag;
    logic [DataW-1:0] w_br, w_bi;
    assign w_tag.action = s_axis_tdata[1:0];
    assign w_tag.a_re   = s_axis_tdata[33:2];
    assign w_tag.a_im   = s_axis_tdata[65:34];
    assign w_br         = s_axis_tdata[97:66];
    assign w_bi         = s_axis_tdata[129:98];

    // Stage 1: add/sub results and the six products.
    logic [DataW:0] w_add_re, w_add_im;
    logic [DataW:0] r_as_re, r_as_im;
    t_tag           r_tag1;
    always_comb begin
        if (w_tag.action == ACT_SUB) begin
            w_add_re = {w_tag.a_re[31], w_tag.a_re} - {w_br[31], w_br};
            w_add_im = {w_tag.a_im[31], w_tag.a_im} - {w_bi[31], w_bi};
        end else begin
            w_add_re = {w_tag.a_re[31], w_tag.a_re} + {w_br[31], w_br};
            w_add_im = {w_tag.a_im[31], w_tag.a_im} + {w_bi[31], w_bi};
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_as_re <= w_add_re;
            r_as_im <= w_add_im;
            r_tag1  <= w_tag;
        end
    end

    logic        p_n[6];
    logic [63:0] p_m[6];
    cau_mul u_m0 (.i_clk, .i_en(w_en), .i_x(w_tag.a_re), .i_y(w_br),
                  .o_neg(p_n[0]), .o_mag(p_m[0]));
    cau_mul u_m1 (.i_clk, .i_en(w_en), .i_x(w_tag.a_im), .i_y(w_bi),
                  .o_neg(p_n[1]), .o_mag(p_m[1]));
    cau_mul u_m2 (.i_clk, .i_en(w_en), .i_x(w_tag.a_re), .i_y(w_bi),
                  .o_neg(p_n[2]), .o_mag(p_m[2]));
    cau_mul u_m3 (.i_clk, .i_en(w_en), .i_x(w_tag.a_im), .i_y(w_br),
                  .o_neg(p_n[3]), .o_mag(p_m[3]));
    cau_mul u_m4 (.i_clk, .i_en(w_en), .i_x(w_br), .i_y(w_br),
                  .o_neg(p_n[4]), .o_mag(p_m[4]));
    cau_mul u_m5 (.i_clk, .i_en(w_en), .i_x(w_bi), .i_y(w_bi),
                  .o_neg(p_n[5]), .o_mag(p_m[5]));

    // Sign/magnitude sum: a +/- b where the sign of b may be flipped.
    function automatic logic [64:0] sm_add(input logic an, input logic [63:0] am,
                                           input logic bn, input logic [63:0] bm);
        logic        n;
        logic [63:0] m;
        if (an == bn) begin
            n = an; m = am + bm;
        end else if (am >= bm) begin
            n = an; m = am - bm;
        end else begin
            n = bn; m = bm - am;
        end
        if (m == 64'd0) n = 1'b0;
        return {n, m};
    endfunction

    // Stage 2: combine products into the two numerators and the denominator.
    logic       w_isdiv;
    logic [64:0] r_pr, r_pi;
    logic [63:0] r_den;
    logic [DataW:0] r_as_re2, r_as_im2;
    t_tag        r_tag2;
    assign w_isdiv = (r_tag1.action == ACT_DIV);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_isdiv) begin
                r_pr <= sm_add(p_n[0], p_m[0], p_n[1], p_m[1]);
                r_pi <= sm_add(p_n[3], p_m[3], !p_n[2] && p_m[2] != 0, p_m[2]);
            end else begin
                r_pr <= sm_add(p_n[0], p_m[0], !p_n[1] && p_m[1] != 0, p_m[1]);
                r_pi <= sm_add(p_n[2], p_m[2], p_n[3], p_m[3]);
            end
            r_den    <= p_m[4] + p_m[5];
            r_as_re2 <= r_as_re;
            r_as_im2 <= r_as_im;
            r_tag2   <= r_tag1;
        end
    end

    // Dividers (QW stages) with a matching delay line for everything else.
    logic [QW-1:0] w_qr, w_qi;
    logic          w_bgr, w_bgi;
    logic [63:0]   w_den_safe;
    assign w_den_safe = (r_den == 64'd0) ? 64'd1 : r_den;
    cau_divpipe #(.FRAC(FRAC_BITS)) u_dr (.i_clk, .i_en(w_en), .i_num(r_pr[63:0]),
        .i_den(w_den_safe), .o_q(w_qr), .o_big(w_bgr));
    cau_divpipe #(.FRAC(FRAC_BITS)) u_di (.i_clk, .i_en(w_en), .i_num(r_pi[63:0]),
        .i_den(w_den_safe), .o_q(w_qi), .o_big(w_bgi));

    logic [64:0]    d_pr  [QW];
    logic [64:0]    d_pi  [QW];
    logic           d_dz  [QW];
    logic [DataW:0] d_sre [QW];
    logic [DataW:0] d_sim [QW];
    t_tag           d_tag [QW];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            d_pr[0]  <= r_pr;
            d_pi[0]  <= r_pi;
            d_dz[0]  <= (r_den == 64'd0);
            d_sre[0] <= r_as_re2;
            d_sim[0] <= r_as_im2;
            d_tag[0] <= r_tag2;
            for (int s = 1; s < QW; s++) begin
                d_pr[s]  <= d_pr[s-1];
                d_pi[s]  <= d_pi[s-1];
                d_dz[s]  <= d_dz[s-1];
                d_sre[s] <= d_sre[s-1];
                d_sim[s] <= d_sim[s-1];
                d_tag[s] <= d_tag[s-1];
            end
        end
    end

    // Stage: saturate and select by operation.
    logic [DataW:0] w_sr, w_si;
    logic [63:0]    w_mr, w_mi;
    logic [DataW-1:0] n_re, n_im;
    logic             n_zd, n_ov;
    t_tag             w_t;
    assign w_t  = d_tag[QW-1];
    assign w_mr = d_pr[QW-1][63:0] >> FRAC_BITS;
    assign w_mi = d_pi[QW-1][63:0] >> FRAC_BITS;
    always_comb begin
        n_zd = 1'b0;
        n_re = '0;
        n_im = '0;
        n_ov = 1'b0;
        w_sr = '0;
        w_si = '0;
        case (w_t.action)
            ACT_ADD, ACT_SUB: begin
                w_sr = sat_sm(d_sre[QW-1][DataW], 64'(d_sre[QW-1][DataW] ?
                       33'(0 - d_sre[QW-1]) : d_sre[QW-1]), 1'b0);
                w_si = sat_sm(d_sim[QW-1][DataW], 64'(d_sim[QW-1][DataW] ?
                       33'(0 - d_sim[QW-1]) : d_sim[QW-1]), 1'b0);
            end
            ACT_MUL: begin
                w_sr = sat_sm(d_pr[QW-1][64] && w_mr != 0, w_mr, 1'b0);
                w_si = sat_sm(d_pi[QW-1][64] && w_mi != 0, w_mi, 1'b0);
            end
            default: begin
                // An oversized quotient keeps the numerator's sign.
                w_sr = sat_sm(d_pr[QW-1][64] && (w_qr != 0 || w_bgr), 64'(w_qr), w_bgr);
                w_si = sat_sm(d_pi[QW-1][64] && (w_qi != 0 || w_bgi), 64'(w_qi), w_bgi);
            end
        endcase
        if (w_t.action == ACT_DIV && d_dz[QW-1]) begin
            n_zd = 1'b1;
            n_re = w_t.a_re;
            n_im = w_t.a_im;
        end else begin
            n_re = w_sr[DataW-1:0];
            n_im = w_si[DataW-1:0];
            n_ov = w_sr[DataW] | w_si[DataW];
        end
    end

    logic [DataW-1:0] r_re, r_im;
    logic             r_zd, r_ov;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_re <= n_re;
            r_im <= n_im;
            r_zd <= n_zd;
            r_ov <= n_ov;
        end
    end

    assign m_axis_tdata = {r_im, r_re};
    assign m_axis_tuser = {r_ov, r_zd};
endmodule
